// File: hdl/lmbs_pkg.sv
// ============================================================================
// lmbs_pkg - shared types and constants of the LED matrix bit-angle scanner
// Request codes, controller states, result flag bundle and field widths.
// ============================================================================
package lmbs_pkg;

	// Field widths fixed by the stream format
	localparam int LEVEL_W = 8;          // pixel brightness word
	localparam int DRIVE_W = 8;          // row and column drive outputs
	localparam int TICKS_W = 16;         // slot tick counter
	localparam int SCALE_W = 8;          // time scale register

	localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = 8'd8;

	// Request codes carried in the input tuser
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_COMMIT = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_READ,
		ST_RESP
	} state_t;

	// Flags of one result transaction
	typedef struct packed {
		logic write_rejected;
		logic commit_applied;
		logic frame_wrapped;
		logic slot_advanced;
	} flags_t;

endpackage

// File: hdl/lmbs_edit_store.sv
// ============================================================================
// lmbs_edit_store - pixel edit memory
// One row of pixels per entry, pixel-wide write enables, registered read.
// Per-pixel valid flops make unwritten pixels read as zero after reset.
// ============================================================================
module lmbs_edit_store #(
	parameter int MATRIX_ROWS    = 8,
	parameter int MATRIX_COLUMNS = 8
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [((MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1)-1:0]       wr_row,
	input  logic [((MATRIX_COLUMNS > 1) ? $clog2(MATRIX_COLUMNS) : 1)-1:0] wr_col,
	input  logic [lmbs_pkg::LEVEL_W-1:0]              wr_level,
	input  logic                                      rd_en,
	input  logic [((MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1)-1:0]       rd_row,
	output logic [MATRIX_COLUMNS*lmbs_pkg::LEVEL_W-1:0] rd_data
);

	localparam int CW = (MATRIX_COLUMNS > 1) ? $clog2(MATRIX_COLUMNS) : 1;
	localparam int LW = lmbs_pkg::LEVEL_W;

	logic [MATRIX_COLUMNS*LW-1:0] mem [MATRIX_ROWS];
	logic [MATRIX_COLUMNS-1:0]    vld_q [MATRIX_ROWS];
	logic [MATRIX_COLUMNS*LW-1:0] rd_word_q;
	logic [MATRIX_COLUMNS-1:0]    rd_vld_q;

	// Memory write, one pixel lane per column
	always_ff @(posedge clk) begin
		for (int c = 0; c < MATRIX_COLUMNS; c++) begin
			if (wr_en && (wr_col == CW'(c))) begin
				mem[wr_row][c*LW +: LW] <= wr_level;
			end
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_row];
		end
	end

	// Pixel valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MATRIX_ROWS; r++) begin
				vld_q[r] <= '0;
			end
			rd_vld_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_row][wr_col] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_row];
			end
		end
	end

	// Unwritten pixels read as zero
	for (genvar c = 0; c < MATRIX_COLUMNS; c++) begin : g_mask
		assign rd_data[c*LW +: LW] = rd_word_q[c*LW +: LW] & {LW{rd_vld_q[c]}};
	end

endmodule

// File: hdl/lmbs_display_store.sv
// ============================================================================
// lmbs_display_store - displayed image memory and column mask former
// One row of pixels per entry, written by the snapshot copy. A registered
// read of the lit row gives the column mask for the selected bit plane.
// ============================================================================
module lmbs_display_store #(
	parameter int MATRIX_ROWS    = 8,
	parameter int MATRIX_COLUMNS = 8,
	parameter int BIT_PLANES     = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        wr_en,
	input  logic [((MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1)-1:0] wr_row,
	input  logic [MATRIX_COLUMNS*lmbs_pkg::LEVEL_W-1:0] wr_data,
	input  logic                                        rd_en,
	input  logic [((MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1)-1:0] rd_row,
	input  logic [((BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1)-1:0]   rd_bit,
	output logic [lmbs_pkg::DRIVE_W-1:0]                column_drive
);

	localparam int BW = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
	localparam int LW = lmbs_pkg::LEVEL_W;

	logic [MATRIX_COLUMNS*LW-1:0] mem [MATRIX_ROWS];
	logic [MATRIX_ROWS-1:0]       row_vld_q;
	logic [MATRIX_COLUMNS*LW-1:0] rd_word_q;
	logic                         rd_vld_q;
	logic [BW-1:0]                rd_bit_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_row];
			rd_bit_q  <= rd_bit;
		end
	end

	// Row valid bits: rows never copied read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_row];
			end
		end
	end

	// Column mask: selected bit of each pixel, low 8 columns only
	for (genvar k = 0; k < lmbs_pkg::DRIVE_W; k++) begin : g_col
		if (k < MATRIX_COLUMNS) begin : g_on
			logic [LW-1:0] pix;
			assign pix = rd_word_q[k*LW +: LW];
			assign column_drive[k] = rd_vld_q & pix[3'(rd_bit_q)];
		end else begin : g_off
			assign column_drive[k] = 1'b0;
		end
	end

endmodule

// File: hdl/lmbs_scan_timer.sv
// ============================================================================
// lmbs_scan_timer - scan slot position and slot tick counter
// Steps bit plane then row on the last tick of a slot and loads the next
// slot length, time_scale shifted left by the next bit number.
// ============================================================================
module lmbs_scan_timer #(
	parameter int MATRIX_ROWS = 8,
	parameter int BIT_PLANES  = 8
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic [lmbs_pkg::SCALE_W-1:0]                           time_scale,
	input  logic                                                   tick,
	output logic [((MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1)-1:0] slot_row,
	output logic [((BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1)-1:0]   slot_bit,
	output lmbs_pkg::flags_t                                       tick_flags
);

	localparam int RW = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
	localparam int BW = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
	localparam int TW = lmbs_pkg::TICKS_W;

	logic [RW-1:0] row_q, row_nxt;
	logic [BW-1:0] bit_q, bit_nxt;
	logic [TW-1:0] left_q;
	logic          slot_end, bit_last, row_last;
	logic [TW-1:0] slot_len;

	// Next slot position
	always_comb begin
		slot_end = (left_q <= TW'(1));
		bit_last = (bit_q == BW'(BIT_PLANES - 1));
		row_last = (row_q == RW'(MATRIX_ROWS - 1));
		bit_nxt  = bit_last ? '0 : bit_q + BW'(1);
		row_nxt  = row_q;
		if (bit_last) begin
			row_nxt = row_last ? '0 : row_q + RW'(1);
		end
		slot_len = {{(TW - lmbs_pkg::SCALE_W){1'b0}}, time_scale} << bit_nxt;
	end

	// Flags of this tick
	always_comb begin
		tick_flags                = '0;
		tick_flags.slot_advanced  = slot_end;
		tick_flags.frame_wrapped  = slot_end & bit_last & row_last;
	end

	// Slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			bit_q  <= '0;
			left_q <= TW'(lmbs_pkg::TIME_SCALE_RESET);
		end else if (tick) begin
			if (slot_end) begin
				row_q  <= row_nxt;
				bit_q  <= bit_nxt;
				left_q <= slot_len;
			end else begin
				left_q <= left_q - TW'(1);
			end
		end
	end

	assign slot_row = row_q;
	assign slot_bit = bit_q;

endmodule

// File: hdl/led_matrix_bitangle_scanner.sv
// ============================================================================
// led_matrix_bitangle_scanner - binary code modulation LED matrix scanner
// Pixel writes land in an edit memory; a commit copies it to the display
// memory at the next frame wrap. Timer ticks step the row / bit plane scan.
//
//   channel  dir  tdata                                tuser
//   s_*      in   [2:0] col, [5:3] row, [13:6] level   [1:0] req_type
//   m_*      out  [7:0] row_drive, [15:8] column_drive [3:0] flags
//   cfg_*    in   cfg_wr_data = time_scale             -
//
// Each input transaction steps through accept, display memory read and result
// load. A tick that wraps the frame with a commit pending adds a copy sweep
// of all MATRIX_ROWS rows, one edit memory row per cycle.
// Reset clears both stores through valid flops; no clearing pass is needed.
// The result register lets the next input be accepted while a result waits;
// the block holds in its result load state only when that register is full.
// ============================================================================
module led_matrix_bitangle_scanner #(
	parameter int MATRIX_COLUMNS = 8,
	parameter int MATRIX_ROWS    = 8,
	parameter int BIT_PLANES     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [2:0] pixel_column, [5:3] pixel_row, [13:6] pixel_level
	input  logic [1:0]  s_tuser,     // [1:0] req_type
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [7:0] row_drive, [15:8] column_drive
	output logic [3:0]  m_tuser,     // [0] slot_advanced, [1] frame_wrapped,
	                                 // [2] commit_applied, [3] write_rejected
	// Configuration
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int RW   = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
	localparam int CW   = (MATRIX_COLUMNS > 1) ? $clog2(MATRIX_COLUMNS) : 1;
	localparam int BW   = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
	localparam int CNTW = $clog2(MATRIX_ROWS + 1);
	localparam int LW   = lmbs_pkg::LEVEL_W;
	localparam int DW   = lmbs_pkg::DRIVE_W;

	lmbs_pkg::state_t state_q, state_nxt;

	// Input fields
	logic [1:0]    req_type;
	logic [2:0]    pixel_column;
	logic [2:0]    pixel_row;
	logic [LW-1:0] pixel_level;

	logic                       s_acc;
	logic                       is_tick;
	logic                       in_range;
	logic                       start_copy;
	logic [lmbs_pkg::SCALE_W-1:0] time_scale_q;
	logic                       pending_q;
	lmbs_pkg::flags_t           flags_q, flags_nxt, tick_flags;

	logic [RW-1:0]   slot_row;
	logic [BW-1:0]   slot_bit;
	logic [DW-1:0]   column_drive;
	logic [DW-1:0]   row_drive;

	logic                       edit_wr_en;
	logic                       edit_rd_en;
	logic [MATRIX_COLUMNS*LW-1:0] edit_rd_data;
	logic                       disp_rd_en;
	logic [CNTW-1:0]            copy_cnt_q;
	logic                       copy_rd;
	logic                       copy_wr_s1;
	logic [RW-1:0]              copy_row_s1;
	logic                       out_load;
	logic                       m_tvalid_q;
	logic [15:0]                m_tdata_q;
	logic [3:0]                 m_tuser_q;

	assign req_type     = s_tuser;
	assign pixel_column = s_tdata[2:0];
	assign pixel_row    = s_tdata[5:3];
	assign pixel_level  = s_tdata[13:6];

	assign s_acc    = s_tvalid & s_tready;
	assign is_tick  = (req_type == lmbs_pkg::REQ_TICK);
	assign in_range = (32'(pixel_row) < MATRIX_ROWS) && (32'(pixel_column) < MATRIX_COLUMNS);
	assign start_copy = s_acc & is_tick & tick_flags.frame_wrapped & pending_q;
	assign copy_rd  = (state_q == lmbs_pkg::ST_COPY) && (copy_cnt_q < CNTW'(MATRIX_ROWS));

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q <= lmbs_pkg::TIME_SCALE_RESET;
		end else if (cfg_wr_en) begin
			time_scale_q <= cfg_wr_data;
		end
	end

	// Scan position and slot timing
	lmbs_scan_timer #(
		.MATRIX_ROWS (MATRIX_ROWS),
		.BIT_PLANES  (BIT_PLANES)
	) u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_scale (time_scale_q),
		.tick       (s_acc & is_tick),
		.slot_row   (slot_row),
		.slot_bit   (slot_bit),
		.tick_flags (tick_flags)
	);

	// Edit memory: written on an accepted in-range write while no commit is pending, read by the copy sweep
	assign edit_wr_en = s_acc && (req_type == lmbs_pkg::REQ_WRITE) && !pending_q && in_range;

	lmbs_edit_store #(
		.MATRIX_ROWS    (MATRIX_ROWS),
		.MATRIX_COLUMNS (MATRIX_COLUMNS)
	) u_edit (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (edit_wr_en),
		.wr_row   (RW'(pixel_row)),
		.wr_col   (CW'(pixel_column)),
		.wr_level (pixel_level),
		.rd_en    (edit_rd_en),
		.rd_row   (copy_cnt_q[RW-1:0]),
		.rd_data  (edit_rd_data)
	);

	// Display memory: written in the cycle after each copy read
	lmbs_display_store #(
		.MATRIX_ROWS    (MATRIX_ROWS),
		.MATRIX_COLUMNS (MATRIX_COLUMNS),
		.BIT_PLANES     (BIT_PLANES)
	) u_disp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (copy_wr_s1),
		.wr_row       (copy_row_s1),
		.wr_data      (edit_rd_data),
		.rd_en        (disp_rd_en),
		.rd_row       (slot_row),
		.rd_bit       (slot_bit),
		.column_drive (column_drive)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lmbs_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_nxt = start_copy ? lmbs_pkg::ST_COPY : lmbs_pkg::ST_READ;
				end
			end
			lmbs_pkg::ST_COPY: begin
				if (copy_cnt_q == CNTW'(MATRIX_ROWS)) begin
					state_nxt = lmbs_pkg::ST_READ;
				end
			end
			lmbs_pkg::ST_READ: begin
				state_nxt = lmbs_pkg::ST_RESP;
			end
			lmbs_pkg::ST_RESP: begin
				if (out_load) begin
					state_nxt = lmbs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lmbs_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready   = 1'b0;
		edit_rd_en = 1'b0;
		disp_rd_en = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			lmbs_pkg::ST_IDLE: s_tready   = 1'b1;
			lmbs_pkg::ST_COPY: edit_rd_en = copy_rd;
			lmbs_pkg::ST_READ: disp_rd_en = 1'b1;
			lmbs_pkg::ST_RESP: out_load   = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// Flags of the accepted transaction
	always_comb begin
		flags_nxt = '0;
		case (req_type)
			lmbs_pkg::REQ_TICK: begin
				flags_nxt                = tick_flags;
				flags_nxt.commit_applied = tick_flags.frame_wrapped & pending_q;
			end
			lmbs_pkg::REQ_WRITE: flags_nxt.write_rejected = pending_q;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lmbs_pkg::ST_IDLE;
			pending_q   <= 1'b0;
			flags_q     <= '0;
			copy_cnt_q  <= '0;
			copy_wr_s1  <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			copy_wr_s1 <= copy_rd;
			if (s_acc) begin
				flags_q    <= flags_nxt;
				copy_cnt_q <= '0;
				if (req_type == lmbs_pkg::REQ_COMMIT) begin
					pending_q <= 1'b1;
				end else if (start_copy) begin
					pending_q <= 1'b0;
				end
			end else if (copy_rd) begin
				copy_cnt_q <= copy_cnt_q + CNTW'(1);
			end
		end
	end

	// Copy write row, taken in the cycle after the read
	always_ff @(posedge clk) begin
		copy_row_s1 <= copy_cnt_q[RW-1:0];
	end

	// Row select, low 8 rows only
	always_comb begin
		for (int i = 0; i < DW; i++) begin
			row_drive[i] = (32'(slot_row) == i);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {column_drive, row_drive};
			m_tuser_q <= flags_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
